FILE: design/sbpa_pkg.sv
// ----------------------------------------------------------------------------
// sbpa_pkg
// Shared types and constants of the slab block pool allocator.
// ----------------------------------------------------------------------------
package sbpa_pkg;

    localparam int SLAB_BLOCKS_DEF = 16;
    localparam int MAX_SLABS_DEF   = 16;

    localparam int HANDLE_W = 8;
    localparam int CNT_W    = 9;
    localparam int SLAB_W   = 5;
    localparam int CFG_W    = 5;
    localparam int KIND_W   = 2;

    localparam logic [CFG_W-1:0] LIMIT_RST = 5'd16;

    typedef enum logic [1:0] {
        K_ALLOC   = 2'd0,
        K_FREE    = 2'd1,
        K_RECLAIM = 2'd2,
        K_NOP     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_NONE = 2'd2,
        ST_FAIL = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_HD,
        S_ADD_WR,
        S_POP_RD,
        S_POP_UPD,
        S_DROP,
        S_SEEK,
        S_RC_RD,
        S_RC_CHK,
        S_FR_CHK,
        S_FR_LINK,
        S_FIN
    } t_state;

    typedef struct packed {
        t_status              status;
        logic [HANDLE_W-1:0]  handle;
        logic [HANDLE_W-1:0]  source;
        logic                 is_move;
    } t_res;

endpackage

FILE: design/sbpa_out_q.sv
// ----------------------------------------------------------------------------
// sbpa_out_q
// Result queue and output register; drains once the step is complete.
// ----------------------------------------------------------------------------
module sbpa_out_q #(
    parameter int SLAB_BLOCKS = sbpa_pkg::SLAB_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  sbpa_pkg::t_res                i_res,
    input  logic                          i_drain,
    input  logic [sbpa_pkg::CNT_W-1:0]    i_free_count,
    input  logic [sbpa_pkg::SLAB_W-1:0]   i_slab_count,
    output logic                          o_busy,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // handle, source, free_count, slab_count, zero pad
    output logic [31:0]                   o_m_tdata,
    // status, is_move
    output logic [2:0]                    o_m_tuser,
    output logic                          o_m_tlast
);
    import sbpa_pkg::*;

    localparam int QAW = $clog2(SLAB_BLOCKS + 1);
    localparam int QD  = 2 ** QAW;

    t_res             m_q [QD];
    t_res             r_qdata;
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             r_pend;
    logic             r_ovalid;
    t_res             r_ores;
    logic [CNT_W-1:0] r_ofree;
    logic [SLAB_W-1:0] r_oslab;
    logic             load, rd_en;

    assign load  = r_pend && (!r_ovalid || i_m_tready);
    assign rd_en = (r_cnt != '0) && i_drain && (!r_pend || load);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            m_q[r_wp] <= i_res;
        end
        if (rd_en) begin
            r_qdata <= m_q[r_rp];
        end
        if (load) begin
            r_ores  <= r_qdata;
            r_ofree <= i_free_count;
            r_oslab <= i_slab_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt  <= r_cnt + {{QAW{1'b0}}, i_push} - {{QAW{1'b0}}, rd_en};
            r_pend <= rd_en || (r_pend && !load);
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_busy     = (r_cnt != '0) || r_pend;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_oslab, r_ofree, r_ores.source, r_ores.handle};
    assign o_m_tuser  = {r_ores.is_move, r_ores.status};
    assign o_m_tlast  = !r_ores.is_move;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= QD)
        else $error("result queue overflow");
    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !rd_en)
        else $error("drain while step still running");
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> $past(rd_en) || $past(r_pend))
        else $error("output loaded without read data");

endmodule

FILE: design/slab_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// slab_block_pool_allocator
// Slab block pool with a doubly linked free list held in on-chip memories.
// ----------------------------------------------------------------------------
// One request at a time. Free pushes a held block at the head; allocate pops
// the head, first adding a slab if the list is empty, which writes the links
// of each block in turn. Reclaim reads each block of the last slab, unlinks
// the free ones and, for each held one, pops head blocks, dropping those of
// the same slab. All results of a step are queued and delivered after the
// step ends, one per cycle when the sink is ready; the next request is taken
// once the queue has drained into the output register. The rate is set by
// one link-memory read per cycle.
module slab_block_pool_allocator #(
    parameter int SLAB_BLOCKS = sbpa_pkg::SLAB_BLOCKS_DEF,
    parameter int MAX_SLABS   = sbpa_pkg::MAX_SLABS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sbpa_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // block
    input  logic [7:0]                    i_s_tdata,
    // kind
    input  logic [sbpa_pkg::KIND_W-1:0]   i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // handle, source, free_count, slab_count, zero pad
    output logic [31:0]                   o_m_tdata,
    // status, is_move
    output logic [2:0]                    o_m_tuser,
    output logic                          o_m_tlast
);
    import sbpa_pkg::*;

    localparam int POOL = MAX_SLABS * SLAB_BLOCKS;
    localparam int AW   = $clog2(POOL);
    localparam int LW   = $clog2(POOL + 1);
    localparam int DW   = $clog2(MAX_SLABS + 1);
    localparam int IW   = $clog2(SLAB_BLOCKS);
    localparam int GW   = $clog2(POOL + 2);
    localparam logic [LW-1:0] NIL   = LW'(POOL);
    localparam logic [LW-1:0] BPS_L = LW'(SLAB_BLOCKS);
    localparam logic [IW-1:0] IDX_LAST = IW'(SLAB_BLOCKS - 1);

    logic [LW-1:0] m_nxt [POOL];
    logic [LW-1:0] m_prv [POOL];
    logic          m_fre [POOL];
    logic [LW-1:0] nxt_q, prv_q;
    logic          fre_q;

    t_state         r_state, n_state;
    logic [LW-1:0]  r_head, n_head;
    logic [LW-1:0]  r_free, n_free;
    logic [DW-1:0]  r_depth, n_depth;
    logic [LW-1:0]  r_end, n_end;
    logic [CFG_W-1:0] r_limit;
    logic [7:0]     r_blk, n_blk;
    logic [LW-1:0]  r_cur, n_cur;
    logic [IW-1:0]  r_idx, n_idx;
    logic [GW-1:0]  r_guard, n_guard;
    logic           r_fail, n_fail;
    logic           r_rc, n_rc;

    logic [AW-1:0]  rd_addr;
    logic           nxt_we, prv_we, fre_we;
    logic [AW-1:0]  nxt_wa, prv_wa, fre_wa;
    logic [LW-1:0]  nxt_wd, prv_wd;
    logic           fre_wd;

    logic           push;
    t_res           res;
    logic           q_busy;
    logic           in_fire;
    logic           full;
    logic [LW-1:0]  cur_b;
    logic [LW-1:0]  blk_l;
    logic           in_slab;
    logic [LW-1:0]  dec_free;

    assign o_s_tready = (r_state == S_IDLE) && !q_busy;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign full       = (int'(r_depth) >= int'(r_limit)) || (int'(r_depth) >= MAX_SLABS);
    assign cur_b      = r_end + LW'(r_idx);
    assign blk_l      = LW'(r_blk);
    assign in_slab    = r_rc && (r_head >= r_end) && (r_head < r_end + BPS_L);
    assign dec_free   = (r_free != '0) ? r_free - 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            m_nxt[nxt_wa] <= nxt_wd;
        end
        if (prv_we) begin
            m_prv[prv_wa] <= prv_wd;
        end
        if (fre_we) begin
            m_fre[fre_wa] <= fre_wd;
        end
        nxt_q <= m_nxt[rd_addr];
        prv_q <= m_prv[rd_addr];
        fre_q <= m_fre[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_free  <= '0;
            r_depth <= '0;
            r_end   <= '0;
            r_limit <= LIMIT_RST;
            r_fail  <= 1'b0;
            r_rc    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_depth <= n_depth;
            r_end   <= n_end;
            r_fail  <= n_fail;
            r_rc    <= n_rc;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk   <= n_blk;
        r_cur   <= n_cur;
        r_idx   <= n_idx;
        r_guard <= n_guard;
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_free  = r_free;
        n_depth = r_depth;
        n_end   = r_end;
        n_blk   = r_blk;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_guard = r_guard;
        n_fail  = r_fail;
        n_rc    = r_rc;
        rd_addr = '0;
        nxt_we  = 1'b0;
        prv_we  = 1'b0;
        fre_we  = 1'b0;
        nxt_wa  = '0;
        prv_wa  = '0;
        fre_wa  = '0;
        nxt_wd  = '0;
        prv_wd  = '0;
        fre_wd  = 1'b0;
        push    = 1'b0;
        res     = '{status: ST_OK, handle: '0, source: '0, is_move: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_blk = i_s_tdata;
                    case (t_kind'(i_s_tuser))
                        K_ALLOC: begin
                            if (r_head != NIL) begin
                                n_rc    = 1'b0;
                                n_state = S_POP_RD;
                            end else if (full) begin
                                push       = 1'b1;
                                res.status = ST_OOM;
                            end else begin
                                n_state = S_ADD_HD;
                            end
                        end
                        K_FREE: begin
                            if (int'(i_s_tdata) < int'(r_end)) begin
                                rd_addr = AW'(i_s_tdata);
                                n_state = S_FR_CHK;
                            end else begin
                                push       = 1'b1;
                                res.handle = i_s_tdata;
                            end
                        end
                        K_RECLAIM: begin
                            if (r_depth == '0 || int'(r_free) < SLAB_BLOCKS) begin
                                push       = 1'b1;
                                res.status = ST_NONE;
                            end else begin
                                n_depth = r_depth - 1'b1;
                                n_end   = r_end - BPS_L;
                                n_idx   = IDX_LAST;
                                n_fail  = 1'b0;
                                n_rc    = 1'b1;
                                n_state = S_RC_RD;
                            end
                        end
                        default: begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD_HD: begin
                if (r_head != NIL) begin
                    prv_we = 1'b1;
                    prv_wa = AW'(r_head);
                    prv_wd = r_end + BPS_L - 1'b1;
                end
                n_idx   = '0;
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                fre_we = 1'b1;
                fre_wa = AW'(cur_b);
                fre_wd = 1'b1;
                nxt_we = 1'b1;
                nxt_wa = AW'(cur_b);
                nxt_wd = (r_idx == IDX_LAST) ? r_head : cur_b + 1'b1;
                prv_we = 1'b1;
                prv_wa = AW'(cur_b);
                prv_wd = (r_idx == '0) ? NIL : cur_b - 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_head  = r_end;
                    n_free  = r_free + BPS_L;
                    n_depth = r_depth + 1'b1;
                    n_end   = r_end + BPS_L;
                    n_rc    = 1'b0;
                    n_state = S_POP_RD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_POP_RD: begin
                rd_addr = AW'(r_head);
                n_state = S_POP_UPD;
            end
            S_POP_UPD: begin
                if (nxt_q != NIL) begin
                    prv_we = 1'b1;
                    prv_wa = AW'(nxt_q);
                    prv_wd = NIL;
                end
                n_head = nxt_q;
                n_free = dec_free;
                fre_we = 1'b1;
                fre_wa = AW'(r_head);
                fre_wd = in_slab;
                if (in_slab) begin
                    nxt_we  = 1'b1;
                    nxt_wa  = AW'(r_head);
                    nxt_wd  = NIL;
                    n_cur   = r_head;
                    n_state = S_DROP;
                end else if (r_rc) begin
                    push        = 1'b1;
                    res.handle  = 8'(r_head);
                    res.source  = 8'(cur_b);
                    res.is_move = 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_RC_RD;
                    end
                end else begin
                    push       = 1'b1;
                    res.handle = 8'(r_head);
                    n_state    = S_IDLE;
                end
            end
            S_DROP: begin
                prv_we  = 1'b1;
                prv_wa  = AW'(r_cur);
                prv_wd  = NIL;
                n_state = S_SEEK;
            end
            S_SEEK: begin
                if (r_head == NIL || int'(r_guard) > POOL) begin
                    n_fail  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_guard = r_guard + 1'b1;
                    n_state = S_POP_RD;
                end
            end
            S_RC_RD: begin
                rd_addr = AW'(cur_b);
                n_state = S_RC_CHK;
            end
            S_RC_CHK: begin
                if (fre_q) begin
                    if (prv_q != NIL || nxt_q != NIL) begin
                        if (prv_q != NIL) begin
                            nxt_we = 1'b1;
                            nxt_wa = AW'(prv_q);
                            nxt_wd = nxt_q;
                        end else begin
                            n_head = nxt_q;
                        end
                        if (nxt_q != NIL) begin
                            prv_we = 1'b1;
                            prv_wa = AW'(nxt_q);
                            prv_wd = prv_q;
                        end
                        n_free = dec_free;
                    end else if (r_head == cur_b) begin
                        n_head = NIL;
                        n_free = '0;
                    end
                    if (r_idx == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_RC_RD;
                    end
                end else begin
                    n_guard = '0;
                    n_state = S_SEEK;
                end
            end
            S_FR_CHK: begin
                if (!fre_q) begin
                    fre_we  = 1'b1;
                    fre_wa  = AW'(blk_l);
                    fre_wd  = 1'b1;
                    nxt_we  = 1'b1;
                    nxt_wa  = AW'(blk_l);
                    nxt_wd  = r_head;
                    prv_we  = 1'b1;
                    prv_wa  = AW'(blk_l);
                    prv_wd  = NIL;
                    n_state = S_FR_LINK;
                end else begin
                    push       = 1'b1;
                    res.handle = r_blk;
                    n_state    = S_IDLE;
                end
            end
            S_FR_LINK: begin
                if (r_head != NIL) begin
                    prv_we = 1'b1;
                    prv_wa = AW'(r_head);
                    prv_wd = blk_l;
                end
                n_head     = blk_l;
                n_free     = r_free + 1'b1;
                push       = 1'b1;
                res.handle = r_blk;
                n_state    = S_IDLE;
            end
            S_FIN: begin
                push       = 1'b1;
                res.status = r_fail ? ST_FAIL : ST_OK;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    sbpa_out_q #(
        .SLAB_BLOCKS (SLAB_BLOCKS)
    ) u_out_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_res        (res),
        .i_drain      (r_state == S_IDLE),
        .i_free_count (CNT_W'(r_free)),
        .i_slab_count (SLAB_W'(r_depth)),
        .o_busy       (q_busy),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

    a_req_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE) || q_busy)
        else $error("request left without a result");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_free) <= POOL)
        else $error("free count beyond pool");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_depth) <= MAX_SLABS)
        else $error("slab count beyond maximum");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the slab block pool allocator. Requests are driven
// with random gaps and a randomly stalling sink, but for a last phase that
// has neither. A model of the slab free list predicts every result, and each
// result is checked in order. Directed tests hit out of memory, bad frees,
// reclaim, no-op and limit changes, then weighted random traffic follows.
// ----------------------------------------------------------------------------
module tb;
    import sbpa_pkg::*;

    localparam int BPS   = 16;
    localparam int NSLAB = 16;
    localparam int POOL  = BPS * NSLAB;
    localparam int NIL   = POOL;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        t_status     status;
        logic [7:0]  handle;
        logic [7:0]  source;
        logic        is_move;
        logic        last;
        logic [8:0]  free_count;
        logic [4:0]  slab_count;
    } t_pool_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    slab_block_pool_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // free list model
    int        lnk_next [POOL];
    int        lnk_prev [POOL];
    bit        blk_free [POOL];
    int        head;
    int        free_tot;
    int        slab_slot [NSLAB];
    int        depth;
    bit        slot_used [NSLAB];
    int        limit;

    t_pool_res expected_q[$];
    int        held_q[$];
    int        mismatches;
    int        cycles;
    bit        idle_en;
    int        hold_len;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit add_slab();
        int lim, s, nxt, b;
        lim = (limit > NSLAB) ? NSLAB : limit;
        if (depth >= lim) return 1'b0;
        for (s = 0; s < NSLAB; s++) if (!slot_used[s]) break;
        if (s >= NSLAB) return 1'b0;
        slot_used[s] = 1'b1;
        slab_slot[depth] = s;
        depth++;
        nxt = head;
        if (nxt != NIL) lnk_prev[nxt] = s * BPS + BPS - 1;
        for (int i = BPS; i > 0; i--) begin
            b = s * BPS + i - 1;
            blk_free[b] = 1'b1;
            lnk_next[b] = nxt;
            lnk_prev[b] = (i > 1) ? b - 1 : NIL;
            nxt = b;
        end
        head = s * BPS;
        free_tot += BPS;
        return 1'b1;
    endfunction

    function automatic int pop_head();
        int b, h;
        b = head;
        h = lnk_next[b];
        if (h != NIL) lnk_prev[h] = NIL;
        head = h;
        if (free_tot > 0) free_tot--;
        blk_free[b] = 1'b0;
        return b;
    endfunction

    function automatic void unlink(int b);
        int p, n;
        p = lnk_prev[b];
        n = lnk_next[b];
        if (p != NIL || n != NIL) begin
            if (p != NIL) lnk_next[p] = n;
            else head = n;
            if (n != NIL) lnk_prev[n] = p;
            if (free_tot > 0) free_tot--;
        end else if (head == b) begin
            head = NIL;
            free_tot = 0;
        end
    endfunction

    function automatic void held_replace(int src, int dst);
        foreach (held_q[i]) begin
            if (held_q[i] == src) begin
                held_q[i] = dst;
                return;
            end
        end
    endfunction

    function automatic void predict_pool(t_kind k, logic [7:0] blk);
        t_pool_res step_q[$];
        t_pool_res r;
        int b, d, s, base, guard;
        bit fail;
        r = '0;
        case (k)
            K_ALLOC: begin
                if (head == NIL) void'(add_slab());
                if (head == NIL) begin
                    r.status = ST_OOM;
                end else begin
                    r.status = ST_OK;
                    r.handle = 8'(pop_head());
                    held_q.push_back(int'(r.handle));
                end
                step_q.push_back(r);
            end
            K_FREE: begin
                b = int'(blk);
                if (slot_used[b / BPS] && !blk_free[b]) begin
                    blk_free[b] = 1'b1;
                    lnk_prev[b] = NIL;
                    lnk_next[b] = head;
                    if (head != NIL) lnk_prev[head] = b;
                    head = b;
                    free_tot++;
                end
                r.status = ST_OK;
                r.handle = blk;
                step_q.push_back(r);
            end
            K_RECLAIM: begin
                if (depth == 0 || free_tot < BPS) begin
                    r.status = ST_NONE;
                    step_q.push_back(r);
                end else begin
                    fail = 1'b0;
                    depth--;
                    s = slab_slot[depth];
                    base = s * BPS;
                    for (int i = BPS; i > 0 && !fail; i--) begin
                        b = base + i - 1;
                        if (blk_free[b]) begin
                            unlink(b);
                        end else begin
                            guard = 0;
                            forever begin
                                if (head == NIL || guard > POOL) begin
                                    fail = 1'b1;
                                    break;
                                end
                                guard++;
                                d = pop_head();
                                if (d >= base && d < base + BPS) begin
                                    blk_free[d] = 1'b1;
                                    lnk_next[d] = NIL;
                                    lnk_prev[d] = NIL;
                                    continue;
                                end
                                r = '0;
                                r.status = ST_OK;
                                r.handle = 8'(d);
                                r.source = 8'(b);
                                r.is_move = 1'b1;
                                step_q.push_back(r);
                                held_replace(b, d);
                                break;
                            end
                        end
                    end
                    slot_used[s] = 1'b0;
                    r = '0;
                    r.status = fail ? ST_FAIL : ST_OK;
                    step_q.push_back(r);
                end
            end
            default: begin
                r.status = ST_OK;
                step_q.push_back(r);
            end
        endcase
        foreach (step_q[i]) begin
            step_q[i].last = (i == step_q.size() - 1);
            step_q[i].free_count = 9'(free_tot);
            step_q[i].slab_count = 5'(depth);
            expected_q.push_back(step_q[i]);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_pool_res got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status     = t_status'(o_m_tuser[1:0]);
            got.is_move    = o_m_tuser[2];
            got.handle     = o_m_tdata[7:0];
            got.source     = o_m_tdata[15:8];
            got.free_count = o_m_tdata[24:16];
            got.slab_count = o_m_tdata[29:25];
            got.last       = o_m_tlast;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p act %p", want, got);
                end
            end
        end
    end

    // sink with random stalls and long hold-offs on demand
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            if (hold_len > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_request(t_kind k, logic [7:0] blk);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= k;
        i_s_tdata  <= blk;
        do @(posedge i_clk); while (!o_s_tready);
        predict_pool(k, blk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [4:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit = int'(val);
    endtask

    task automatic free_held();
        int idx;
        idx = $urandom_range(0, held_q.size() - 1);
        send_request(K_FREE, 8'(held_q[idx]));
        held_q.delete(idx);
    endtask

    task automatic test_directed();
        send_request(K_NOP, 8'd0);
        send_request(K_RECLAIM, 8'd0);
        send_request(K_FREE, 8'd255);
        send_request(K_ALLOC, 8'd0);
        send_request(K_ALLOC, 8'd0);
        send_request(K_FREE, 8'd1);
        send_request(K_FREE, 8'd1);
        send_request(K_FREE, 8'd170);
        repeat (17) send_request(K_ALLOC, 8'hff);
    endtask

    task automatic test_limits();
        write_limit(5'd1);
        repeat (20) send_request(K_ALLOC, 8'd0);
        send_request(K_RECLAIM, 8'd0);
        write_limit(5'd0);
        while (held_q.size() > 0) free_held();
        send_request(K_RECLAIM, 8'd0);
        send_request(K_ALLOC, 8'd0);
        write_limit(5'd31);
    endtask

    task automatic test_reclaim_moves();
        write_limit(5'd3);
        repeat (44) send_request(K_ALLOC, 8'd0);
        repeat (20) free_held();
        send_request(K_RECLAIM, 8'd0);
        send_request(K_RECLAIM, 8'd0);
    endtask

    task automatic test_random(int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) send_request(K_ALLOC, 8'($urandom));
            else if (sel < 80 && held_q.size() > 0) free_held();
            else if (sel < 86) send_request(K_FREE, 8'($urandom_range(0, 255)));
            else if (sel < 95) send_request(K_RECLAIM, 8'($urandom));
            else send_request(K_NOP, 8'($urandom));
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= K_NOP;
        cycles      = 0;
        mismatches  = 0;
        hold_len    = 0;
        idle_en     = 1'b1;
        head        = NIL;
        free_tot    = 0;
        depth       = 0;
        limit       = int'(LIMIT_RST);
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limits();
        test_reclaim_moves();
        hold_len = 400;
        test_random(30);
        write_limit(5'd16);
        test_random(70);
        write_limit(5'($urandom_range(1, 16)));
        test_random(60);
        drain();
        idle_en = 1'b0;
        test_random(40);
        drain();

        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
design/sbpa_pkg.sv
design/sbpa_out_q.sv
design/slab_block_pool_allocator.sv
tb/tb.sv
